### rtl/acs_pkg.sv
// Shared types and constants for the anneal cycle sequencer.
// Used by acs_step and anneal_cycle_sequencer; no dependencies.
package acs_pkg;

    localparam int unsigned SETPOINT_MAX_DEF   = 9999;
    localparam int unsigned SETPOINT_RESET_DEF = 100;

    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned SETPOINT_W = 14;
    localparam int unsigned TIMER_W    = 18;
    localparam int unsigned SECONDS_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned MS_PER_SEC = 1000;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_START = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HEAT  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DROP  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DROPT = 3'd5;
    localparam logic [PHASE_W-1:0] PH_COOL  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ON_SENSOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_SECONDS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_SECONDS = 2'd2;

    typedef struct packed {
        logic                 start_on_sensor;
        logic [SECONDS_W-1:0] drop_seconds;
        logic [SECONDS_W-1:0] cooldown_seconds;
    } cfg_t;

    typedef struct packed {
        logic              tick;
        logic              start_button;
        logic              stop_button;
        logic              knob_click;
        logic signed [7:0] knob_steps;
        logic              part_present;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0]    phase;
        logic [TIMER_W-1:0]    elapsed_ms;
        logic [SETPOINT_W-1:0] setpoint;
        logic                  heater;
        logic                  solenoid;
    } state_t;

endpackage

### rtl/anneal_cycle_sequencer.sv
// Top level of the anneal cycle sequencer: input register, state and result registers.
// Depends on acs_pkg and acs_step.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   in      | in_valid/in_ready  | tick, start_button, stop_button, knob_click,
//           |                    | knob_steps, part_present
//   out     | out_valid/out_ready| phase, heater_on, solenoid_on, exit_request,
//           |                    | heat_centiseconds
//   cfg     | cfg_wr_en          | cfg_index, cfg_wdata
//
// A result is valid after its input passes the input register and the state register;
// one transaction per cycle sustained while out_ready holds; acs_step is combinational.
// A stalled output holds its result plus at most one more transaction in the input
// register, then in_ready drops. Reset returns to idle with outputs off.
module anneal_cycle_sequencer #(
    parameter int unsigned SETPOINT_MAX   = acs_pkg::SETPOINT_MAX_DEF,
    parameter int unsigned SETPOINT_RESET = acs_pkg::SETPOINT_RESET_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [acs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               tick,
    input  logic                               start_button,
    input  logic                               stop_button,
    input  logic                               knob_click,
    input  logic signed [7:0]                  knob_steps,
    input  logic                               part_present,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [acs_pkg::PHASE_W-1:0]        phase,
    output logic                               heater_on,
    output logic                               solenoid_on,
    output logic                               exit_request,
    output logic [acs_pkg::SETPOINT_W-1:0]     heat_centiseconds
);

    acs_pkg::cfg_t   cfg_reg;
    acs_pkg::item_t  item_reg;
    logic            item_valid_reg;
    acs_pkg::state_t state_reg;
    acs_pkg::state_t state_next;
    logic            exit_reg;
    logic            exit_next;
    logic            out_valid_reg;
    logic            advance;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_on_sensor  <= 1'b0;
            cfg_reg.drop_seconds     <= 8'd1;
            cfg_reg.cooldown_seconds <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                acs_pkg::CFG_START_ON_SENSOR:  cfg_reg.start_on_sensor  <= cfg_wdata[0];
                acs_pkg::CFG_DROP_SECONDS:     cfg_reg.drop_seconds     <= cfg_wdata;
                acs_pkg::CFG_COOLDOWN_SECONDS: cfg_reg.cooldown_seconds <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.tick         <= tick;
            item_reg.start_button <= start_button;
            item_reg.stop_button  <= stop_button;
            item_reg.knob_click   <= knob_click;
            item_reg.knob_steps   <= knob_steps;
            item_reg.part_present <= part_present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    acs_step #(
        .SETPOINT_MAX (SETPOINT_MAX)
    ) u_step (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .exit_next  (exit_next)
    );

    // state doubles as the result register: it only moves when a result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= acs_pkg::PH_IDLE;
            state_reg.elapsed_ms <= '0;
            state_reg.setpoint   <= acs_pkg::SETPOINT_W'(SETPOINT_RESET);
            state_reg.heater     <= 1'b0;
            state_reg.solenoid   <= 1'b0;
            exit_reg             <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            exit_reg  <= exit_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign phase             = state_reg.phase;
    assign heater_on         = state_reg.heater;
    assign solenoid_on       = state_reg.solenoid;
    assign exit_request      = exit_reg;
    assign heat_centiseconds = state_reg.setpoint;

endmodule

### rtl/acs_step.sv
// Next-state logic of the anneal cycle sequencer for one transaction.
// Depends on acs_pkg.
module acs_step #(
    parameter int unsigned SETPOINT_MAX = acs_pkg::SETPOINT_MAX_DEF
) (
    input  acs_pkg::cfg_t   cfg,
    input  acs_pkg::item_t  item,
    input  acs_pkg::state_t state,
    output acs_pkg::state_t state_next,
    output logic            exit_next
);

    localparam logic [acs_pkg::SETPOINT_W-1:0] SP_MAX = acs_pkg::SETPOINT_W'(SETPOINT_MAX);

    logic                           was_idle;
    logic                           abort;
    logic [acs_pkg::TIMER_W-1:0]    elapsed_tick;
    logic signed [15:0]             sp_sum;
    logic [acs_pkg::SETPOINT_W-1:0] sp_new;
    logic [acs_pkg::TIMER_W-1:0]    heat_ms;
    logic [acs_pkg::TIMER_W-1:0]    drop_ms;
    logic [acs_pkg::TIMER_W-1:0]    cool_ms;
    acs_pkg::state_t                mid;

    always_comb
    begin
        was_idle  = (state.phase == acs_pkg::PH_IDLE);
        exit_next = item.knob_click && was_idle;
        abort     = (item.stop_button || item.knob_click) && !was_idle;

        elapsed_tick = (item.tick && state.elapsed_ms != acs_pkg::TIMER_MAX)
                     ? state.elapsed_ms + acs_pkg::TIMER_W'(1) : state.elapsed_ms;

        mid            = state;
        mid.elapsed_ms = elapsed_tick;
        if (abort)
        begin
            mid.phase    = acs_pkg::PH_IDLE;
            mid.heater   = 1'b0;
            mid.solenoid = 1'b0;
        end

        // set point adjust, saturating to 0..max
        sp_sum = $signed({2'b00, state.setpoint}) + $signed({{8{item.knob_steps[7]}},
                 item.knob_steps});
        if (sp_sum < 16'sd0)
            sp_new = '0;
        else if (sp_sum > $signed({2'b00, SP_MAX}))
            sp_new = SP_MAX;
        else
            sp_new = sp_sum[acs_pkg::SETPOINT_W-1:0];
        if (mid.phase == acs_pkg::PH_IDLE && item.knob_steps != 8'sd0 && !exit_next)
            mid.setpoint = sp_new;

        heat_ms = ({4'b0000, mid.setpoint} << 3) + ({4'b0000, mid.setpoint} << 1);
        drop_ms = acs_pkg::TIMER_W'(cfg.drop_seconds) * acs_pkg::TIMER_W'(acs_pkg::MS_PER_SEC);
        cool_ms = acs_pkg::TIMER_W'(cfg.cooldown_seconds)
                * acs_pkg::TIMER_W'(acs_pkg::MS_PER_SEC);

        state_next = mid;
        unique case (mid.phase)
            acs_pkg::PH_IDLE:
            begin
                if (item.start_button && was_idle)
                    state_next.phase = acs_pkg::PH_WAIT;
            end
            acs_pkg::PH_WAIT:
            begin
                if (!cfg.start_on_sensor || item.part_present)
                    state_next.phase = acs_pkg::PH_START;
            end
            acs_pkg::PH_START:
            begin
                state_next.phase      = acs_pkg::PH_HEAT;
                state_next.heater     = 1'b1;
                state_next.elapsed_ms = '0;
            end
            acs_pkg::PH_HEAT:
            begin
                if (mid.elapsed_ms >= heat_ms)
                begin
                    state_next.heater     = 1'b0;
                    state_next.phase      = acs_pkg::PH_DROP;
                    state_next.elapsed_ms = '0;
                end
            end
            acs_pkg::PH_DROP:
            begin
                state_next.solenoid = 1'b1;
                state_next.phase    = acs_pkg::PH_DROPT;
            end
            acs_pkg::PH_DROPT:
            begin
                if (mid.elapsed_ms >= drop_ms)
                begin
                    state_next.solenoid   = 1'b0;
                    state_next.phase      = acs_pkg::PH_COOL;
                    state_next.elapsed_ms = '0;
                end
            end
            acs_pkg::PH_COOL:
            begin
                if (mid.elapsed_ms >= cool_ms)
                    state_next.phase = acs_pkg::PH_WAIT;
            end
            default:
            begin
                state_next.phase    = acs_pkg::PH_IDLE;
                state_next.heater   = 1'b0;
                state_next.solenoid = 1'b0;
            end
        endcase
    end

endmodule

### tb/testbench.sv
// Self-checking testbench for anneal_cycle_sequencer: directed and random event transactions.
// Depends on acs_pkg and the RTL; predicts every result transaction and checks it field by field.
`timescale 1ns / 1ps

module testbench;
    import acs_pkg::*;

    localparam int SP_MAX         = SETPOINT_MAX_DEF;
    localparam int SP_RESET       = SETPOINT_RESET_DEF;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam logic [22:0] READY_PATTERN = 23'h6F5B7D;

    typedef struct packed {
        logic [PHASE_W-1:0]    phase;
        logic                  heater;
        logic                  solenoid;
        logic                  exit_req;
        logic [SETPOINT_W-1:0] setpoint;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic tick = 1'b0;
    logic start_button = 1'b0;
    logic stop_button = 1'b0;
    logic knob_click = 1'b0;
    logic signed [7:0] knob_steps = '0;
    logic part_present = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [PHASE_W-1:0] phase;
    logic heater_on;
    logic solenoid_on;
    logic exit_request;
    logic [SETPOINT_W-1:0] heat_centiseconds;

    // Predicted sequencer state and register copy
    logic [PHASE_W-1:0]    sp_phase;
    logic [TIMER_W-1:0]    sp_ms;
    logic [SETPOINT_W-1:0] sp_setpoint;
    logic                  sp_heater;
    logic                  sp_solenoid;
    cfg_t                  cfg_now;

    status_t awaited_status[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    logic rx_stalls = 1'b1;
    logic hold_req = 1'b0;
    int  hold_left = 0;
    int  rx_slot = 0;

    anneal_cycle_sequencer #(
        .SETPOINT_MAX   (SP_MAX),
        .SETPOINT_RESET (SP_RESET)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .tick              (tick),
        .start_button      (start_button),
        .stop_button       (stop_button),
        .knob_click        (knob_click),
        .knob_steps        (knob_steps),
        .part_present      (part_present),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .phase             (phase),
        .heater_on         (heater_on),
        .solenoid_on       (solenoid_on),
        .exit_request      (exit_request),
        .heat_centiseconds (heat_centiseconds)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic status_t annealer_next(input item_t it);
        status_t r;
        logic    was_idle;
        logic    start_ok;
        logic    exit_req;
        int      level;
        was_idle = (sp_phase == PH_IDLE);
        start_ok = it.start_button && was_idle;
        exit_req = it.knob_click && was_idle;
        if (it.tick && sp_ms != TIMER_MAX)
            sp_ms = sp_ms + 1'b1;
        if ((it.stop_button || it.knob_click) && !was_idle)
        begin
            sp_phase = PH_IDLE;
            sp_heater = 1'b0;
            sp_solenoid = 1'b0;
        end
        if (sp_phase == PH_IDLE && it.knob_steps != 0 && !exit_req)
        begin
            level = int'(sp_setpoint) + int'($signed(it.knob_steps));
            if (level < 0)
                level = 0;
            if (level > SP_MAX)
                level = SP_MAX;
            sp_setpoint = level[SETPOINT_W-1:0];
        end
        case (sp_phase)
            PH_IDLE:
                if (start_ok)
                    sp_phase = PH_WAIT;
            PH_WAIT:
                if (!cfg_now.start_on_sensor || it.part_present)
                    sp_phase = PH_START;
            PH_START:
            begin
                sp_phase = PH_HEAT;
                sp_heater = 1'b1;
                sp_ms = '0;
            end
            PH_HEAT:
                if (int'(sp_ms) >= int'(sp_setpoint) * 10)
                begin
                    sp_heater = 1'b0;
                    sp_phase = PH_DROP;
                    sp_ms = '0;
                end
            PH_DROP:
            begin
                sp_solenoid = 1'b1;
                sp_phase = PH_DROPT;
            end
            PH_DROPT:
                if (int'(sp_ms) >= int'(cfg_now.drop_seconds) * int'(MS_PER_SEC))
                begin
                    sp_solenoid = 1'b0;
                    sp_phase = PH_COOL;
                    sp_ms = '0;
                end
            PH_COOL:
                if (int'(sp_ms) >= int'(cfg_now.cooldown_seconds) * int'(MS_PER_SEC))
                    sp_phase = PH_WAIT;
            default:
            begin
                sp_phase = PH_IDLE;
                sp_heater = 1'b0;
                sp_solenoid = 1'b0;
            end
        endcase
        r.phase = sp_phase;
        r.heater = sp_heater;
        r.solenoid = sp_solenoid;
        r.exit_req = exit_req;
        r.setpoint = sp_setpoint;
        return r;
    endfunction

    // Result side: checks each accepted transaction, then drives out_ready
    always @(posedge clk)
    begin : status_sink
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_status.size() == 0)
            begin
                $error("unexpected result transaction, phase %0d", phase);
                mismatch_count++;
            end
            else
            begin
                want = awaited_status.pop_front();
                if (phase !== want.phase)
                begin
                    $error("phase: expected %0d, actual %0d", want.phase, phase);
                    mismatch_count++;
                end
                if (heater_on !== want.heater)
                begin
                    $error("heater_on: expected %0d, actual %0d", want.heater, heater_on);
                    mismatch_count++;
                end
                if (solenoid_on !== want.solenoid)
                begin
                    $error("solenoid_on: expected %0d, actual %0d", want.solenoid, solenoid_on);
                    mismatch_count++;
                end
                if (exit_request !== want.exit_req)
                begin
                    $error("exit_request: expected %0d, actual %0d", want.exit_req,
                           exit_request);
                    mismatch_count++;
                end
                if (heat_centiseconds !== want.setpoint)
                begin
                    $error("heat_centiseconds: expected %0d, actual %0d", want.setpoint,
                           heat_centiseconds);
                    mismatch_count++;
                end
            end
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_left = HOLDOFF_CYCLES;
            hold_req <= 1'b0;
            out_ready <= 1'b0;
        end
        else if (rx_stalls)
        begin
            out_ready <= READY_PATTERN[rx_slot];
            rx_slot = (rx_slot == 22) ? 0 : rx_slot + 1;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic item_t mk_item(input logic tk, input logic st, input logic sp,
                                      input logic ck, input logic [7:0] steps,
                                      input logic pt);
        item_t it;
        it.tick = tk;
        it.start_button = st;
        it.stop_button = sp;
        it.knob_click = ck;
        it.knob_steps = steps;
        it.part_present = pt;
        return it;
    endfunction

    // Sends one input transaction, in bursts with random gaps when gaps_on is set; predicts on acceptance
    task automatic push_event(input item_t it);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0)
            burst_left--;
        in_valid <= 1'b1;
        tick <= it.tick;
        start_button <= it.start_button;
        stop_button <= it.stop_button;
        knob_click <= it.knob_click;
        knob_steps <= it.knob_steps;
        part_present <= it.part_present;
        do @(posedge clk); while (!in_ready);
        awaited_status.push_back(annealer_next(it));
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic sensor, input logic [7:0] drop_s,
                             input logic [7:0] cool_s);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_ON_SENSOR;
        cfg_wdata <= {7'd0, sensor};
        @(posedge clk);
        cfg_index <= CFG_DROP_SECONDS;
        cfg_wdata <= drop_s;
        @(posedge clk);
        cfg_index <= CFG_COOLDOWN_SECONDS;
        cfg_wdata <= cool_s;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_now.start_on_sensor = sensor;
        cfg_now.drop_seconds = drop_s;
        cfg_now.cooldown_seconds = cool_s;
    endtask

    // Mostly well-formed cycles: short set points, start while idle, ticks, rare aborts
    function automatic item_t pick_item();
        item_t       it;
        int unsigned roll;
        roll = $urandom_range(99);
        it.tick = ($urandom_range(9) != 0);
        it.start_button = 1'b0;
        it.stop_button = ($urandom_range(399) == 0);
        it.knob_click = ($urandom_range(399) == 0);
        it.knob_steps = '0;
        it.part_present = $urandom_range(1);
        if (roll < 3)
        begin
            it.tick = $urandom_range(1);
            it.start_button = $urandom_range(1);
            it.stop_button = ($urandom_range(7) == 0);
            it.knob_click = ($urandom_range(7) == 0);
            it.knob_steps = 8'($urandom_range(255));
        end
        else if (sp_phase == PH_IDLE)
        begin
            it.start_button = ($urandom_range(3) == 0);
            it.knob_click = ($urandom_range(29) == 0);
            if (sp_setpoint > 8)
                it.knob_steps = 8'($urandom_range(128, 255));
            else if (roll < 50)
                it.knob_steps = 8'($urandom_range(0, 6));
            else if (roll < 70)
                it.knob_steps = 8'($urandom_range(250, 255));
        end
        else
        begin
            it.start_button = ($urandom_range(9) == 0);
            if (roll < 25)
                it.knob_steps = 8'($urandom_range(255));
        end
        return it;
    endfunction

    task automatic test_reset_defaults();
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1));
        push_event(mk_item(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0));
        repeat (3) push_event(mk_item(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
    endtask

    task automatic test_directed_cases();
        configure(1'b0, 8'd0, 8'd0);
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h7F, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h80, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h80, 1'b0));
        push_event(mk_item(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b1, 1'b0, 1'b0, 8'd5, 1'b0));
        push_event(mk_item(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        // abort and start together: start must not be honored
        push_event(mk_item(1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b1, 8'd3, 1'b0));
        push_event(mk_item(1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b1, 8'd4, 1'b0));
        push_event(mk_item(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1));
        push_event(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 1'b1));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    endtask

    task automatic test_setpoint_limits();
        repeat (80) push_event(mk_item(1'($urandom_range(1)), 1'b0, 1'b0, 1'b0, 8'h7F, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd1, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        repeat (80) push_event(mk_item(1'($urandom_range(1)), 1'b0, 1'b0, 1'b0, 8'h80, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b0));
    endtask

    // One full cycle with a one-second drop, sensor gated
    task automatic test_timed_cycle();
        bit seen_cool;
        int waited;
        seen_cool = 1'b0;
        waited = 0;
        configure(1'b1, 8'd1, 8'd0);
        push_event(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h80, 1'b0));
        push_event(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'd7, 1'b0));
        push_event(mk_item(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0));
        while (!(seen_cool && sp_phase == PH_WAIT))
        begin
            if (sp_phase == PH_COOL)
                seen_cool = 1'b1;
            if (sp_phase == PH_WAIT)
                waited++;
            push_event(mk_item(1'b1, 1'b0, 1'b0, 1'b0,
                               8'($urandom_range(255)), waited > 3));
        end
        push_event(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        rx_stalls <= 1'b0;
        repeat (24)
            push_event(mk_item(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'($urandom_range(1))));
        push_event(mk_item(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0));
        repeat (12) push_event(mk_item(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1));
        push_event(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
        rx_stalls <= 1'b1;
        gaps_on = 1'b1;
    endtask

    task automatic test_output_holdoff();
        hold_req <= 1'b1;
        gaps_on = 1'b0;
        repeat (80) push_event(pick_item());
        gaps_on = 1'b1;
    endtask

    task automatic test_random_cycles();
        configure(1'b1, 8'd0, 8'd0);
        repeat (250) push_event(pick_item());
        configure(1'b0, 8'd255, 8'd255);
        repeat (100) push_event(pick_item());
        configure(1'b0, 8'd0, 8'd0);
        repeat (200) push_event(pick_item());
    endtask

    initial
    begin
        sp_phase = PH_IDLE;
        sp_ms = '0;
        sp_setpoint = SP_RESET[SETPOINT_W-1:0];
        sp_heater = 1'b0;
        sp_solenoid = 1'b0;
        cfg_now.start_on_sensor = 1'b0;
        cfg_now.drop_seconds = 8'd1;
        cfg_now.cooldown_seconds = 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_setpoint_limits();
        test_timed_cycle();
        test_back_to_back();
        test_output_holdoff();
        test_random_cycles();
        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/acs_pkg.sv
rtl/acs_step.sv
rtl/anneal_cycle_sequencer.sv
tb/testbench.sv
